[rtl/i2csbf_pkg.sv]
`timescale 1ns / 1ps

package i2csbf_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_PUT   = 2'd1,
        OP_GET   = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // m_tdata bit positions
    localparam int M_ACCEPTED_BIT = 0;
    localparam int M_TX_VALID_BIT = 9;
    localparam int M_ADDR_ACK_BIT = 19;
    localparam int M_STOP_ACK_BIT = 20;
    localparam int M_TX_EMPTY_BIT = 21;

endpackage

[rtl/i2c_slave_byte_fifo_controller.sv]
`timescale 1ns / 1ps
// An input beat passes the input register and then the result register before its result beat.
// Throughput: one item per cycle while m_tready is high; the result register frees a slot in the same cycle
// that m_tready takes the previous result.
// Ring reads come from a registered head word per ring, written through on a same-slot write.
// Reset (aresetn low, synchronous): mode idle, ring pointers zero, transmit interrupt off,
// event_enable off, no items held. Ring contents are not cleared.
module i2c_slave_byte_fifo_controller
    import i2csbf_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // event_enable register
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // addr_match, master_reads, rx_byte_event, tx_idle_event, stop_event, data_byte[7:0]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted, rx_byte[7:0], tx_byte_valid, tx_byte[7:0], tx_int_on, addr_ack,
    // stop_ack, tx_empty, rx_available, bus_mode[1:0]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

    // input register
    logic           in_valid_reg;
    logic [1:0]     op_reg;
    logic           addr_match_reg;
    logic           master_reads_reg;
    logic           rx_ev_reg;
    logic           tx_ev_reg;
    logic           stop_reg;
    logic [7:0]     byte_reg;

    // block state
    logic           event_enable_reg;
    mode_t          mode_reg,   mode_next;
    logic           irq_reg,    irq_next;
    logic [TX_AW-1:0] tx_wr_reg, tx_wr_next;
    logic [TX_AW-1:0] tx_rd_reg, tx_rd_next;
    logic [RX_AW-1:0] rx_wr_reg, rx_wr_next;
    logic [RX_AW-1:0] rx_rd_reg, rx_rd_next;

    // rings and their registered head words
    logic [7:0]     tx_mem [TX_DEPTH];
    logic [7:0]     rx_mem [RX_DEPTH];
    logic [7:0]     tx_head_reg;
    logic [7:0]     rx_head_reg;
    logic           tx_we;
    logic           rx_we;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    logic           s_fire;
    logic           proc_fire;
    logic           ev;
    mode_t          mode_a;
    logic [TX_AW-1:0] tx_wr_inc;
    logic           accepted;
    logic [7:0]     rx_byte;
    logic           tx_valid;
    logic [7:0]     tx_byte;
    logic           addr_ack;
    logic           stop_ack;
    logic           tx_empty;
    logic           rx_avail;

    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign tx_wr_inc = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;

    always_comb begin
        mode_next  = mode_reg;
        irq_next   = irq_reg;
        tx_wr_next = tx_wr_reg;
        tx_rd_next = tx_rd_reg;
        rx_wr_next = rx_wr_reg;
        rx_rd_next = rx_rd_reg;
        tx_we      = 1'b0;
        rx_we      = 1'b0;
        accepted   = 1'b0;
        rx_byte    = '0;
        tx_valid   = 1'b0;
        tx_byte    = '0;
        addr_ack   = 1'b0;
        stop_ack   = 1'b0;
        ev         = 1'b0;
        mode_a     = mode_reg;

        if (proc_fire) begin
            unique case (opcode_t'(op_reg))
                OP_EVENT: begin
                    ev = event_enable_reg;
                    if (ev) begin
                        // address match first; later flags see the new mode
                        if (addr_match_reg) begin
                            mode_a   = master_reads_reg ? MODE_TX : MODE_RX;
                            addr_ack = 1'b1;
                            if (master_reads_reg) begin
                                irq_next = 1'b1;
                            end
                        end
                        if (rx_ev_reg && mode_a == MODE_RX) begin
                            rx_we      = 1'b1;
                            rx_wr_next = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
                        end
                        if (tx_ev_reg && mode_a == MODE_TX) begin
                            if (tx_rd_reg != tx_wr_reg) begin
                                tx_valid   = 1'b1;
                                tx_byte    = tx_head_reg;
                                irq_next   = 1'b1;
                                tx_rd_next = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;
                            end else begin
                                irq_next = 1'b0;
                            end
                        end
                        mode_next = mode_a;
                        if (stop_reg) begin
                            stop_ack = 1'b1;
                            if (mode_a == MODE_RX || tx_rd_next == tx_wr_reg) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                end
                OP_PUT: begin
                    // one slot stays free so full and empty differ
                    if (tx_wr_inc != tx_rd_reg) begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_inc;
                        accepted   = 1'b1;
                    end
                end
                OP_GET: begin
                    if (rx_rd_reg != rx_wr_reg) begin
                        rx_byte    = rx_head_reg;
                        rx_rd_next = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
                        accepted   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        tx_empty    = (tx_rd_next == tx_wr_next) && (mode_next != MODE_TX);
        rx_avail    = (rx_rd_next != rx_wr_next);
        m_data_next = {7'b0, mode_next, rx_avail, tx_empty, stop_ack, addr_ack, irq_next,
                       tx_byte, tx_valid, rx_byte, accepted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            event_enable_reg <= 1'b0;
            mode_reg         <= MODE_IDLE;
            irq_reg          <= 1'b0;
            tx_wr_reg        <= '0;
            tx_rd_reg        <= '0;
            rx_wr_reg        <= '0;
            rx_rd_reg        <= '0;
        end else begin
            if (cfg_we) begin
                event_enable_reg <= cfg_wdata;
            end
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            mode_reg  <= mode_next;
            irq_reg   <= irq_next;
            tx_wr_reg <= tx_wr_next;
            tx_rd_reg <= tx_rd_next;
            rx_wr_reg <= rx_wr_next;
            rx_rd_reg <= rx_rd_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg           <= s_tuser[1:0];
            addr_match_reg   <= s_tdata[0];
            master_reads_reg <= s_tdata[1];
            rx_ev_reg        <= s_tdata[2];
            tx_ev_reg        <= s_tdata[3];
            stop_reg         <= s_tdata[4];
            byte_reg         <= s_tdata[12:5];
        end
        if (proc_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // rings: head word tracks the slot at the next read pointer
    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wr_reg] <= byte_reg;
        end
        if (tx_we && tx_wr_reg == tx_rd_next) begin
            tx_head_reg <= byte_reg;
        end else begin
            tx_head_reg <= tx_mem[tx_rd_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wr_reg] <= byte_reg;
        end
        if (rx_we && rx_wr_reg == rx_rd_next) begin
            rx_head_reg <= byte_reg;
        end else begin
            rx_head_reg <= rx_mem[rx_rd_next];
        end
    end

endmodule

[rtl/i2csbf_checker.sv]
`timescale 1ns / 1ps

module i2csbf_assertions
    import i2csbf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // nothing left over from before reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // bytes read as zero unless their valid flag is set
    a_bytes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TX_VALID_BIT] || m_tdata[17:10] == 8'd0)
                  && (m_tdata[M_ACCEPTED_BIT] || m_tdata[8:1] == 8'd0))
        else $error("byte field set without its valid flag");

    // software ops never carry bus acks
    a_ack_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_ACCEPTED_BIT]
                       && (m_tdata[M_ADDR_ACK_BIT] || m_tdata[M_STOP_ACK_BIT])))
        else $error("accepted together with a bus ack");

    a_mode_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:23] != 2'd3
                  && !(m_tdata[24:23] == MODE_TX && m_tdata[M_TX_EMPTY_BIT]))
        else $error("bad mode or tx_empty while transmitting");

endmodule

bind i2c_slave_byte_fifo_controller i2csbf_assertions u_i2csbf_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
